FILE: rtl/core/grid_bilinear_remap_assert.svh
// Assertion macros shared by the grid remap RTL.
// Needs clk_i and rst_ni in the including module.
`ifndef GRID_BILINEAR_REMAP_ASSERT_SVH
`define GRID_BILINEAR_REMAP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define GBR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("grid remap assertion failed");

// Next-cycle implication, checked out of reset
`define GBR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("grid remap assertion failed");

`endif

FILE: rtl/core/gbr_pkg.sv
// Package for the bilinear grid remap: widths, field types and codes.
// Used by every module in rtl/core.
`default_nettype none
package gbr_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PT_W      = 26;
  localparam int unsigned Q_W       = 24;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned BANK_AW   = 2 * (IDX_W - 1);
  localparam int unsigned PAIR_W    = 2 * PT_W;
  localparam int unsigned A_W       = PT_W + FRAC_BITS + 2;
  localparam int unsigned D_W       = A_W + 1;
  localparam int unsigned P_W       = D_W + FRAC_BITS + 1;
  localparam int unsigned S_W       = P_W + 2;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [IDX_W-1:0] REG_X_CELLS = 8'd0;
  localparam logic [IDX_W-1:0] REG_Y_CELLS = 8'd1;

  typedef struct packed {
    logic               valid;
    logic               oob;
    logic               col_odd;
    logic               row_odd;
    logic [FRAC_BITS-1:0] dx;
    logic [FRAC_BITS-1:0] dy;
  } gbr_meta_t;
endpackage
`default_nettype wire

FILE: rtl/core/gbr_grid_mem.sv
// Grid point store: four banks split by column and row parity, so the four
// corners of any cell are read in the same cycle. Depends on gbr_pkg.
`default_nettype none
module gbr_grid_mem import gbr_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [1:0]        wbank_i,
  input  wire logic [BANK_AW-1:0] waddr_i,
  input  wire logic [PAIR_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [BANK_AW-1:0] raddr_i [4],
  output logic      [PAIR_W-1:0] rdata_o [4]
);
  // bank index = {row parity, column parity}
  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [PAIR_W-1:0] mem [2**BANK_AW];
    logic [PAIR_W-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (we_i && (wbank_i == 2'(b))) begin
        mem[waddr_i] <= wdata_i;
      end
      if (re_i) begin
        rd_q <= mem[raddr_i[b]];
      end
    end
    assign rdata_o[b] = rd_q;
  end
endmodule
`default_nettype wire

FILE: rtl/core/gbr_blend.sv
// One axis of the bilinear blend, three register stages, exact until the
// final round to nearest. Depends on gbr_pkg.
`default_nettype none
module gbr_blend import gbr_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [PT_W-1:0] g00_i,
  input  wire logic signed [PT_W-1:0] g10_i,
  input  wire logic signed [PT_W-1:0] g01_i,
  input  wire logic signed [PT_W-1:0] g11_i,
  input  wire logic [FRAC_BITS-1:0] dx_i,
  input  wire logic [FRAC_BITS-1:0] dy_i,
  output logic signed [PT_W-1:0]    res_o
);
  logic signed [A_W-1:0]  a_d, b_d, a_q, b_q, a2_q;
  logic signed [PT_W:0]   dif_a, dif_b;
  logic signed [FRAC_BITS:0] dxs, dys;
  logic [FRAC_BITS-1:0]   dy_q;
  logic signed [D_W-1:0]  d;
  logic signed [P_W-1:0]  prod_q;
  logic signed [S_W-1:0]  sum;
  logic signed [PT_W-1:0] res_q;

  // stage 1: row blends a = g00 + dx*(g10-g00), scaled by 2^F
  assign dxs   = $signed({1'b0, dx_i});
  assign dif_a = PT_W'(0) + ($signed({g10_i[PT_W-1], g10_i}) - $signed({g00_i[PT_W-1], g00_i}));
  assign dif_b = $signed({g11_i[PT_W-1], g11_i}) - $signed({g01_i[PT_W-1], g01_i});
  assign a_d   = (A_W'(g00_i) <<< FRAC_BITS) + A_W'(dxs * dif_a);
  assign b_d   = (A_W'(g01_i) <<< FRAC_BITS) + A_W'(dxs * dif_b);

  // stage 2: dy*(b-a)
  assign dys = $signed({1'b0, dy_q});
  assign d   = D_W'(b_q) - D_W'(a_q);

  // stage 3: a*2^F + dy*(b-a) + half, floor by 2^(2F)
  assign sum = (S_W'(a2_q) <<< FRAC_BITS) + S_W'(prod_q)
             + (S_W'(1) <<< (2 * FRAC_BITS - 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q    <= a_d;
      b_q    <= b_d;
      dy_q   <= dy_i;
      a2_q   <= a_q;
      prod_q <= P_W'(dys * d);
      res_q  <= sum[2*FRAC_BITS +: PT_W];
    end
  end
  assign res_o = res_q;
endmodule
`default_nettype wire

FILE: rtl/core/grid_bilinear_remap.sv
// Bilinear grid remap: load words store one grid point, query words return
// the blend of the four corners round the coordinate, one word per cycle.
// A query result is offered once it has passed the bank read register and
// the three blend stages; loads give no word. A result held by the receiver
// stalls the whole pipe and the input with it. The rate is set by the
// four-bank grid store, which reads a whole cell per cycle, and the
// three-stage multiply pipeline behind it. The store has no reset; points
// must be loaded before a query touches them.
`default_nettype none
module grid_bilinear_remap import gbr_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // config write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [7:0]   cfg_data_i,
  // input words
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // grid_col, grid_row, point_x, point_y, query_x, query_y
  input  wire logic [119:0] s_axis_tdata,
  // kind
  input  wire logic         s_axis_tuser,
  // result words
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // mapped_x, mapped_y
  output logic [55:0]       m_axis_tdata,
  // out_of_bounds
  output logic              m_axis_tuser
);
  logic [IDX_W-1:0] x_cells_q, y_cells_q;
  logic en, acc, acc_load, acc_query;
  logic [IDX_W-1:0] col, row, ix, iy, ix1, iy1;
  logic [Q_W-1:0] qx, qy;
  logic [BANK_AW-1:0] raddr [4];
  logic [PAIR_W-1:0] rdata [4];
  logic [PAIR_W-1:0] c00, c10, c01, c11;
  gbr_meta_t m0, m1_q, m2_q, m3_q, m4_q;
  logic signed [PT_W-1:0] rx, ry;

  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_cells_q <= 8'd255;
      y_cells_q <= 8'd255;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_X_CELLS: x_cells_q <= cfg_data_i;
        REG_Y_CELLS: y_cells_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline moves unless the output word is held
  assign en            = !m4_q.valid || m_axis_tready;
  assign s_axis_tready = en;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign acc_load      = acc && (s_axis_tuser == KIND_LOAD);
  assign acc_query     = acc && (s_axis_tuser == KIND_QUERY);

  assign col = s_axis_tdata[7:0];
  assign row = s_axis_tdata[15:8];
  assign qx  = s_axis_tdata[91:68];
  assign qy  = s_axis_tdata[115:92];
  assign ix  = qx[Q_W-1 -: IDX_W];
  assign iy  = qy[Q_W-1 -: IDX_W];
  assign ix1 = ix + IDX_W'(1);
  assign iy1 = iy + IDX_W'(1);

  // each bank takes whichever corner row/column has its parity
  for (genvar b = 0; b < 4; b++) begin : g_addr
    logic [IDX_W-1:0] cx, cy;
    assign cx = (ix[0] == 1'(b % 2)) ? ix : ix1;
    assign cy = (iy[0] == 1'(b / 2)) ? iy : iy1;
    assign raddr[b] = {cy[IDX_W-1:1], cx[IDX_W-1:1]};
  end

  gbr_grid_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (acc_load),
    .wbank_i ({row[0], col[0]}),
    .waddr_i ({row[IDX_W-1:1], col[IDX_W-1:1]}),
    .wdata_i ({s_axis_tdata[67:42], s_axis_tdata[41:16]}),
    .re_i    (acc_query),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // query side-band carried alongside the read
  always_comb begin
    m0.valid   = acc_query;
    m0.oob     = (ix >= x_cells_q) || (iy >= y_cells_q);
    m0.col_odd = ix[0];
    m0.row_odd = iy[0];
    m0.dx      = qx[FRAC_BITS-1:0];
    m0.dy      = qy[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_q <= '0;
      m2_q <= '0;
      m3_q <= '0;
      m4_q <= '0;
    end else if (en) begin
      m1_q <= m0;
      m2_q <= m1_q;
      m3_q <= m2_q;
      m4_q <= m3_q;
    end
  end

  // sort bank outputs back into cell corners
  assign c00 = rdata[{m1_q.row_odd,  m1_q.col_odd}];
  assign c10 = rdata[{m1_q.row_odd, !m1_q.col_odd}];
  assign c01 = rdata[{!m1_q.row_odd,  m1_q.col_odd}];
  assign c11 = rdata[{!m1_q.row_odd, !m1_q.col_odd}];

  gbr_blend u_blend_x (
    .clk_i (clk_i), .en_i (en),
    .g00_i (c00[PT_W-1:0]), .g10_i (c10[PT_W-1:0]),
    .g01_i (c01[PT_W-1:0]), .g11_i (c11[PT_W-1:0]),
    .dx_i  (m1_q.dx), .dy_i (m1_q.dy), .res_o (rx)
  );

  gbr_blend u_blend_y (
    .clk_i (clk_i), .en_i (en),
    .g00_i (c00[PAIR_W-1:PT_W]), .g10_i (c10[PAIR_W-1:PT_W]),
    .g01_i (c01[PAIR_W-1:PT_W]), .g11_i (c11[PAIR_W-1:PT_W]),
    .dx_i  (m1_q.dx), .dy_i (m1_q.dy), .res_o (ry)
  );

  // out-of-bounds words carry zero coordinates
  assign m_axis_tvalid = m4_q.valid;
  assign m_axis_tuser  = m4_q.oob;
  assign m_axis_tdata  = m4_q.oob ? '0 : {4'b0, ry, rx};

`include "grid_bilinear_remap_assert.svh"
  `GBR_ASSERT_IMP(a_oob_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `GBR_ASSERT_NXT(a_query_enters, acc_query, m1_q.valid)
  `GBR_ASSERT_NXT(a_load_no_word, acc_load, !m1_q.valid)
  `GBR_ASSERT_IMP(a_out_from_pipe, $rose(m_axis_tvalid), $past(m3_q.valid))
endmodule
`default_nettype wire
